// File: hw/rtl/cdsd_pkg.sv
`timescale 1ns / 1ps
// cdsd_pkg: command and result beat types, field widths and command codes of the card deck core
package cdsd_pkg;

	localparam int FUNC_W     = 2;
	localparam int RND_W      = 16;
	localparam int RND_CNT_W  = $clog2(RND_W);
	localparam int SUIT_W     = 3;
	localparam int SUIT_OUT_W = 2;
	localparam int RANK_W     = 4;
	localparam int CARD_W     = SUIT_OUT_W + RANK_W;
	localparam int LEFT_W     = 6;

	localparam logic [FUNC_W-1:0] FUNC_RESTART = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_SHUFFLE = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_DRAW    = 2'd2;

	typedef struct packed {
		logic [FUNC_W-1:0] func;
		logic [RND_W-1:0]  random_value;
	} cmd_t;

	typedef struct packed {
		logic                  card_valid;
		logic [SUIT_OUT_W-1:0] card_suit;
		logic [RANK_W-1:0]     card_rank;
		logic [LEFT_W-1:0]     cards_left;
		logic                  shuffle_done;
	} result_t;

endpackage

// File: hw/rtl/cdsd_ram.sv
`timescale 1ns / 1ps
// cdsd_ram: generic single-write, single-read ram with registered read data
module cdsd_ram #(
	parameter int WIDTH = 6,
	parameter int DEPTH = 52
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// File: hw/rtl/cdsd_mod.sv
`timescale 1ns / 1ps
// cdsd_mod: bit-serial restoring remainder of the random word by the shuffle span
module cdsd_mod #(
	parameter int DIV_W = 6
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [cdsd_pkg::RND_W-1:0]  dividend,
	input  logic [DIV_W-1:0]            divisor,
	output logic                        done,
	output logic [DIV_W-1:0]            remainder
);

	localparam logic [cdsd_pkg::RND_CNT_W-1:0] LAST_BIT =
		(cdsd_pkg::RND_CNT_W)'(cdsd_pkg::RND_W - 1);

	logic                             run_q;
	logic                             done_q;
	logic [cdsd_pkg::RND_CNT_W-1:0]   cnt_q;
	logic [cdsd_pkg::RND_W-1:0]       dvd_q;
	logic [DIV_W-1:0]                 div_q;
	logic [DIV_W-1:0]                 rem_q;
	logic [DIV_W:0]                   trial;
	logic [DIV_W:0]                   diff;
	logic [DIV_W-1:0]                 rem_nxt;

	assign trial   = {rem_q, dvd_q[cdsd_pkg::RND_W-1]};
	assign diff    = trial - {1'b0, div_q};
	assign rem_nxt = (trial >= {1'b0, div_q}) ? diff[DIV_W-1:0] : trial[DIV_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			dvd_q  <= '0;
			div_q  <= '0;
			rem_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
				dvd_q <= dividend;
				div_q <= divisor;
				rem_q <= '0;
			end else if (run_q) begin
				rem_q <= rem_nxt;
				dvd_q <= {dvd_q[cdsd_pkg::RND_W-2:0], 1'b0};
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == LAST_BIT) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done      = done_q;
	assign remainder = rem_q;

endmodule

// File: hw/rtl/card_deck_shuffle_draw_core.sv
`timescale 1ns / 1ps
// card_deck_shuffle_draw_core: card deck in ram with stepwise shuffle and draw
//
// A command beat (func, random_value) is taken on a clock edge with start high and busy low.
// Every command gives exactly one result beat, shown on result for one cycle with done high;
// the receiver cannot stall it, so it must take the beat in that cycle.
// What each command does from accept to the done cycle:
//   restart  the fill writes one deck entry per cycle through the ram port
//   shuffle  the bit-serial remainder of random_value, then read i, read j,
//            write i, write j on the single ram port; status only once all steps are done
//   draw     one ram read of the top card; status only on an empty deck
//   other    status only
// busy is low in the done cycle, so the next command may be taken there.
// After reset the deck is empty, the shuffle step is zero and no shuffle is done; the deck
// store is not cleared, and a restart must come before the first shuffle step.
// Draws report empty until the last shuffle step after a restart.
module card_deck_shuffle_draw_core #(
	parameter int SUITS = 4,
	parameter int RANKS = 13
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  cdsd_pkg::cmd_t      cmd,
	output logic                busy,
	output logic                done,
	output cdsd_pkg::result_t   result
);

	localparam int DECK   = SUITS * RANKS;
	localparam int ADDR_W = (DECK > 1) ? $clog2(DECK) : 1;
	localparam int CNT_W  = $clog2(DECK + 1);

	localparam logic [CNT_W-1:0]            DECK_C    = CNT_W'(DECK);
	localparam logic [CNT_W-1:0]            LAST_STEP = CNT_W'(DECK - 1);
	localparam logic [ADDR_W-1:0]           LAST_ADDR = ADDR_W'(DECK - 1);
	localparam logic [cdsd_pkg::RANK_W-1:0] LAST_RANK = (cdsd_pkg::RANK_W)'(RANKS - 1);

	typedef enum logic [6:0] {
		ST_IDLE = 7'b0000001,
		ST_FILL = 7'b0000010,
		ST_MOD  = 7'b0000100,
		ST_RDJ  = 7'b0001000,
		ST_WRI  = 7'b0010000,
		ST_WRJ  = 7'b0100000,
		ST_DRAW = 7'b1000000
	} state_t;

	state_t                         state_q;
	logic [CNT_W-1:0]               step_q;
	logic [CNT_W-1:0]               left_q;
	logic                           shuf_done_q;
	logic [ADDR_W-1:0]              pos_q;
	logic [cdsd_pkg::SUIT_W-1:0]    suit_q;
	logic [cdsd_pkg::RANK_W-1:0]    rank_q;
	logic [ADDR_W-1:0]              j_q;
	logic [cdsd_pkg::CARD_W-1:0]    a_q;
	logic                           done_q;
	cdsd_pkg::result_t              res_q;

	logic                           can_step;
	logic [CNT_W-1:0]               left_dec;
	logic [CNT_W-1:0]               step_nxt;
	logic                           mod_start;
	logic                           mod_done;
	logic [CNT_W-1:0]               mod_rem;
	logic                           ram_we;
	logic [ADDR_W-1:0]              ram_waddr;
	logic [cdsd_pkg::CARD_W-1:0]    ram_wdata;
	logic [ADDR_W-1:0]              ram_raddr;
	logic [cdsd_pkg::CARD_W-1:0]    ram_rdata;
	cdsd_pkg::result_t              draw_beat;

	function automatic cdsd_pkg::result_t status_beat(input logic [CNT_W-1:0] left,
			input logic sd);
		cdsd_pkg::result_t              r;
		logic [CNT_W+cdsd_pkg::LEFT_W-1:0] ext;
		ext            = {{cdsd_pkg::LEFT_W{1'b0}}, left};
		r              = '0;
		r.cards_left   = ext[cdsd_pkg::LEFT_W-1:0];
		r.shuffle_done = sd;
		return r;
	endfunction

	assign busy      = (state_q != ST_IDLE);
	assign can_step  = !shuf_done_q && (step_q < LAST_STEP);
	assign left_dec  = left_q - 1'b1;
	assign step_nxt  = step_q + 1'b1;
	assign mod_start = start && (state_q == ST_IDLE) &&
		(cmd.func == cdsd_pkg::FUNC_SHUFFLE) && can_step;

	always_comb begin
		draw_beat            = status_beat(left_q, shuf_done_q);
		draw_beat.card_valid = 1'b1;
		draw_beat.card_suit  = ram_rdata[cdsd_pkg::CARD_W-1:cdsd_pkg::RANK_W];
		draw_beat.card_rank  = ram_rdata[cdsd_pkg::RANK_W-1:0];
	end

	// single ram port schedule
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = pos_q;
		ram_wdata = {suit_q[cdsd_pkg::SUIT_OUT_W-1:0], rank_q};
		ram_raddr = step_q[ADDR_W-1:0];
		unique case (state_q)
			ST_IDLE: ram_raddr = left_dec[ADDR_W-1:0];
			ST_FILL: ram_we = 1'b1;
			ST_MOD:  ram_raddr = step_q[ADDR_W-1:0];
			ST_RDJ:  ram_raddr = j_q;
			ST_WRI: begin
				ram_we    = 1'b1;
				ram_waddr = step_q[ADDR_W-1:0];
				ram_wdata = ram_rdata;
			end
			ST_WRJ: begin
				ram_we    = 1'b1;
				ram_waddr = j_q;
				ram_wdata = a_q;
			end
			ST_DRAW: ram_raddr = left_q[ADDR_W-1:0];
			default: ram_we = 1'b0;
		endcase
	end

	cdsd_ram #(
		.WIDTH (cdsd_pkg::CARD_W),
		.DEPTH (DECK)
	) u_deck (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	cdsd_mod #(
		.DIV_W (CNT_W)
	) u_mod (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (mod_start),
		.dividend  (cmd.random_value),
		.divisor   (DECK_C - step_q),
		.done      (mod_done),
		.remainder (mod_rem)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			step_q      <= '0;
			left_q      <= '0;
			shuf_done_q <= 1'b0;
			pos_q       <= '0;
			suit_q      <= '0;
			rank_q      <= '0;
			j_q         <= '0;
			a_q         <= '0;
			done_q      <= 1'b0;
			res_q       <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						unique case (cmd.func)
							cdsd_pkg::FUNC_RESTART: begin
								pos_q   <= '0;
								suit_q  <= '0;
								rank_q  <= '0;
								state_q <= ST_FILL;
							end
							cdsd_pkg::FUNC_SHUFFLE: begin
								if (can_step) begin
									state_q <= ST_MOD;
								end else begin
									res_q  <= status_beat(left_q, shuf_done_q);
									done_q <= 1'b1;
								end
							end
							cdsd_pkg::FUNC_DRAW: begin
								if (left_q != '0) begin
									left_q  <= left_dec;
									state_q <= ST_DRAW;
								end else begin
									res_q  <= status_beat(left_q, shuf_done_q);
									done_q <= 1'b1;
								end
							end
							default: begin
								res_q  <= status_beat(left_q, shuf_done_q);
								done_q <= 1'b1;
							end
						endcase
					end
				end
				ST_FILL: begin
					if (pos_q == LAST_ADDR) begin
						step_q      <= '0;
						shuf_done_q <= (LAST_STEP == '0);
						left_q      <= (LAST_STEP == '0) ? DECK_C : '0;
						res_q       <= status_beat((LAST_STEP == '0) ? DECK_C : '0,
							(LAST_STEP == '0));
						done_q      <= 1'b1;
						state_q     <= ST_IDLE;
					end else begin
						pos_q <= pos_q + 1'b1;
						if (rank_q == LAST_RANK) begin
							rank_q <= '0;
							suit_q <= suit_q + 1'b1;
						end else begin
							rank_q <= rank_q + 1'b1;
						end
					end
				end
				ST_MOD: begin
					if (mod_done) begin
						j_q     <= mod_rem[ADDR_W-1:0] + step_q[ADDR_W-1:0];
						state_q <= ST_RDJ;
					end
				end
				ST_RDJ: begin
					a_q     <= ram_rdata;
					state_q <= ST_WRI;
				end
				ST_WRI: begin
					state_q <= ST_WRJ;
				end
				ST_WRJ: begin
					step_q <= step_nxt;
					if (step_nxt == LAST_STEP) begin
						shuf_done_q <= 1'b1;
						left_q      <= DECK_C;
						res_q       <= status_beat(DECK_C, 1'b1);
					end else begin
						res_q <= status_beat(left_q, shuf_done_q);
					end
					done_q  <= 1'b1;
					state_q <= ST_IDLE;
				end
				ST_DRAW: begin
					res_q   <= draw_beat;
					done_q  <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign done   = done_q;
	assign result = res_q;

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result beat while busy");

	a_card_from_draw: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.card_valid |-> $past(state_q == ST_DRAW))
		else $error("card returned outside a draw");

	a_empty_until_shuffled: assert property (@(posedge clk) disable iff (!arst_n)
		done && !result.shuffle_done |-> result.cards_left == '0)
		else $error("cards left before shuffle finished");

	a_mod_in_step: assert property (@(posedge clk) disable iff (!arst_n)
		mod_done |-> state_q == ST_MOD)
		else $error("remainder finished outside a shuffle step");

endmodule

// File: tb/tb.sv
`timescale 1ns / 1ps
// tb: self-checking testbench for card_deck_shuffle_draw_core, deck model with random shuffles and deals
module tb;

	localparam int SUITS_N     = 4;
	localparam int RANKS_N     = 13;
	localparam int DECK_CARDS  = SUITS_N * RANKS_N;
	localparam int RESTART_LAT = DECK_CARDS + 1;
	localparam int ITEMS_GOAL  = 1850;
	localparam int STALL_LIMIT = 400;

	localparam logic [cdsd_pkg::FUNC_W-1:0] FUNC_UNUSED = 2'd3;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              start = 1'b0;
	cdsd_pkg::cmd_t    cmd = '0;
	logic              busy;
	logic              done;
	cdsd_pkg::result_t result;

	// predicted deck state
	logic [5:0] deck_model [DECK_CARDS];
	int         shuffle_pos = 0;
	int         cards_left_m = 0;
	logic       shuffled = 1'b0;

	cdsd_pkg::result_t pending_results [$];
	int      err_count = 0;
	int      items_sent = 0;
	int      next_gap = 0;
	bit      idle_en = 1'b1;
	int      stall_cycles = 0;

	card_deck_shuffle_draw_core #(
		.SUITS(SUITS_N),
		.RANKS(RANKS_N)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.cmd(cmd),
		.busy(busy),
		.done(done),
		.result(result)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic cdsd_pkg::result_t deal_predict(cdsd_pkg::cmd_t c);
		cdsd_pkg::result_t r;
		logic [5:0] tmp;
		logic [5:0] code;
		int j;
		r = '0;
		case (c.func)
			cdsd_pkg::FUNC_RESTART: begin
				for (int k = 0; k < DECK_CARDS; k++)
					deck_model[k] = {2'(k / RANKS_N), 4'(k % RANKS_N)};
				shuffle_pos = 0;
				cards_left_m = 0;
				shuffled = 1'b0;
			end
			cdsd_pkg::FUNC_SHUFFLE: begin
				if (!shuffled && shuffle_pos + 1 < DECK_CARDS) begin
					j = int'(c.random_value) % (DECK_CARDS - shuffle_pos) + shuffle_pos;
					tmp = deck_model[shuffle_pos];
					deck_model[shuffle_pos] = deck_model[j];
					deck_model[j] = tmp;
					shuffle_pos++;
					if (shuffle_pos + 1 >= DECK_CARDS) begin
						shuffled = 1'b1;
						cards_left_m = DECK_CARDS;
					end
				end
			end
			cdsd_pkg::FUNC_DRAW: begin
				if (cards_left_m > 0) begin
					cards_left_m--;
					code = deck_model[cards_left_m];
					r.card_valid = 1'b1;
					r.card_suit = code[5:4];
					r.card_rank = code[3:0];
				end
			end
			default: ;
		endcase
		r.cards_left = (cdsd_pkg::LEFT_W)'(cards_left_m);
		r.shuffle_done = shuffled;
		return r;
	endfunction

	function automatic logic [cdsd_pkg::RND_W-1:0] rnd_word();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return '1;
			default: return (cdsd_pkg::RND_W)'($urandom_range(0, 65535));
		endcase
	endfunction

	task automatic report_mismatch(string msg);
		$display("[%0t] mismatch: %s", $time, msg);
		err_count++;
	endtask

	// one command beat; start stays high across back-to-back beats
	task automatic send_cmd(logic [cdsd_pkg::FUNC_W-1:0] f, logic [cdsd_pkg::RND_W-1:0] v);
		cdsd_pkg::cmd_t beat;
		beat.func = f;
		beat.random_value = v;
		repeat (next_gap) @(posedge clk);
		start <= 1'b1;
		cmd <= beat;
		do @(posedge clk); while (busy !== 1'b0);
		pending_results.push_back(deal_predict(beat));
		if (f != FUNC_UNUSED)
			items_sent++;
		next_gap = idle_en ? $urandom_range(0, 14) : 0;
		if (next_gap > 0)
			start <= 1'b0;
	endtask

	task automatic send_noise();
		send_cmd($urandom_range(0, 1) ? FUNC_UNUSED : cdsd_pkg::FUNC_DRAW, rnd_word());
	endtask

	task automatic drain_results();
		if (next_gap == 0)
			start <= 1'b0;
		do @(posedge clk); while (pending_results.size() != 0);
		next_gap = 0;
	endtask

	task automatic test_empty_after_reset();
		send_cmd(cdsd_pkg::FUNC_DRAW, '0);
		send_cmd(FUNC_UNUSED, '1);
		send_cmd(cdsd_pkg::FUNC_DRAW, '1);
	endtask

	task automatic test_shuffle_edges();
		send_cmd(cdsd_pkg::FUNC_RESTART, '1);
		send_cmd(cdsd_pkg::FUNC_SHUFFLE, '0);
		send_cmd(cdsd_pkg::FUNC_SHUFFLE, '1);
		send_cmd(cdsd_pkg::FUNC_DRAW, 16'h1234);
		send_cmd(FUNC_UNUSED, 16'h5555);
		send_cmd(cdsd_pkg::FUNC_RESTART, 16'hAAAA);
		send_cmd(cdsd_pkg::FUNC_SHUFFLE, 16'h8000);
		send_cmd(cdsd_pkg::FUNC_SHUFFLE, 16'h0001);
		send_cmd(cdsd_pkg::FUNC_SHUFFLE, 16'h7FFF);
	endtask

	task automatic test_hold_off();
		send_cmd(cdsd_pkg::FUNC_RESTART, '0);
		drain_results();
		send_cmd(cdsd_pkg::FUNC_SHUFFLE, 16'd51);
		send_cmd(cdsd_pkg::FUNC_DRAW, '0);
		drain_results();
	endtask

	task automatic test_random_games();
		int n_draws;
		while (items_sent < ITEMS_GOAL) begin
			idle_en = ($urandom_range(0, 3) != 0);
			send_cmd(cdsd_pkg::FUNC_RESTART, rnd_word());
			for (int s = 0; s < DECK_CARDS - 1; s++) begin
				if ($urandom_range(0, 99) < 4)
					send_noise();
				if ($urandom_range(0, 299) == 0) begin
					// broken sequence: start over mid-shuffle
					send_cmd(cdsd_pkg::FUNC_RESTART, rnd_word());
					s = 0;
				end
				send_cmd(cdsd_pkg::FUNC_SHUFFLE, rnd_word());
			end
			repeat ($urandom_range(0, 2)) send_cmd(cdsd_pkg::FUNC_SHUFFLE, rnd_word());
			if ($urandom_range(0, 3) == 0)
				drain_results();
			n_draws = $urandom_range(30, DECK_CARDS + 4);
			repeat (n_draws) begin
				if ($urandom_range(0, 99) < 4)
					send_noise();
				send_cmd(cdsd_pkg::FUNC_DRAW, rnd_word());
			end
		end
	endtask

	task automatic finish_run();
		if (next_gap == 0)
			start <= 1'b0;
		do @(posedge clk); while (pending_results.size() != 0);
		repeat (RESTART_LAT + 8) @(posedge clk);
		if (err_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		test_empty_after_reset();
		test_shuffle_edges();
		test_hold_off();
		test_random_games();
		finish_run();
	end

	// result beat check
	always @(posedge clk) begin
		cdsd_pkg::result_t want;
		if (arst_n && done === 1'b1) begin
			if (pending_results.size() == 0) begin
				report_mismatch("result beat with nothing pending");
			end else begin
				want = pending_results.pop_front();
				if (result.card_valid !== want.card_valid)
					report_mismatch($sformatf("card_valid got %0b want %0b",
						result.card_valid, want.card_valid));
				if (result.card_suit !== want.card_suit)
					report_mismatch($sformatf("card_suit got %0d want %0d",
						result.card_suit, want.card_suit));
				if (result.card_rank !== want.card_rank)
					report_mismatch($sformatf("card_rank got %0d want %0d",
						result.card_rank, want.card_rank));
				if (result.cards_left !== want.cards_left)
					report_mismatch($sformatf("cards_left got %0d want %0d",
						result.cards_left, want.cards_left));
				if (result.shuffle_done !== want.shuffle_done)
					report_mismatch($sformatf("shuffle_done got %0b want %0b",
						result.shuffle_done, want.shuffle_done));
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((start && busy === 1'b0) || done === 1'b1) begin
				stall_cycles <= 0;
			end else if (stall_cycles >= STALL_LIMIT) begin
				$display("Regression FAIL");
				$finish;
			end else begin
				stall_cycles <= stall_cycles + 1;
			end
		end
	end

endmodule

// File: files.f
hw/rtl/cdsd_pkg.sv
hw/rtl/cdsd_ram.sv
hw/rtl/cdsd_mod.sv
hw/rtl/card_deck_shuffle_draw_core.sv
tb/tb.sv
